// ===== hdl/buzzer_pattern_queue_player_assert.svh =====
// Assertion macros for the buzzer pattern player.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef BUZZER_PATTERN_QUEUE_PLAYER_ASSERT_SVH
`define BUZZER_PATTERN_QUEUE_PLAYER_ASSERT_SVH

// Property checked on every rising edge, masked while reset is asserted.
`define BPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for properties that must also hold while reset is asserted.
`define BPQ_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bpq_pkg.sv =====
// Shared types, constants and helpers for the buzzer pattern player.
// No dependencies; imported by the controller, datapath and top level.
package bpq_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam logic BOARD_ACTIVE_LEVEL = 1'b1;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_PLAY = 2'd1,
    FN_STOP = 2'd2,
    FN_CONT = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] time_now;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  beep_count;
    logic        continuous_enable;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic accepted;
    logic busy_res;
  } out_result_t;

  typedef struct packed {
    logic [15:0] on_t;
    logic [15:0] off_t;
    logic [7:0]  reps;
  } pat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch transaction, read queue head
    logic execute;   // apply transaction, load result register
  } bpq_cmd_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/bpq_ctrl.sv =====
// Sequencing controller for the buzzer pattern player.
// Depends on bpq_pkg; drives busy, result strobe and datapath commands.
module bpq_ctrl
  import bpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output bpq_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   strobe_r;

  always_comb begin
    cmd.capture = start && (state_r == ST_IDLE);
    cmd.execute = (state_r == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          strobe_r <= 1'b1;
          state_r  <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r == ST_EXEC);
  assign out_strobe = strobe_r;

endmodule

// ===== hdl/bpq_dp.sv =====
// Datapath of the buzzer pattern player: pattern queue, timing state, result.
// Depends on bpq_pkg; steered by bpq_ctrl through bpq_cmd_t.
module bpq_dp
  import bpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bpq_cmd_t    cmd,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output out_result_t out_result
);

  // pattern queue storage, no reset; a slot is used only after being written
  pat_t pat_mem [QUEUE_DEPTH];

  in_item_t          item_r;
  pat_t              head_r;
  out_result_t       res_r;
  logic              act_lvl_r;

  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  pat_t              cur_r, cur_nxt;
  logic [7:0]        beeps_r, beeps_nxt;
  logic [31:0]       deadline_r, deadline_nxt;
  logic              running_r, running_nxt;
  logic              on_phase_r, on_phase_nxt;
  logic              gap_r, gap_nxt;
  logic              steady_r, steady_nxt;
  logic              drive_r, drive_nxt;

  logic              acc;
  logic              q_empty;
  logic              reached;
  logic [31:0]       elapsed;
  logic [7:0]        beeps_dec;
  logic [SLOT_W-1:0] wr_next;
  logic              mem_we;

  assign elapsed = item_r.time_now - deadline_r;
  assign reached = ~elapsed[31];
  assign q_empty = (wr_slot_r == rd_slot_r);
  assign wr_next = next_slot(wr_slot_r);
  assign beeps_dec = (beeps_r != 8'd0) ? beeps_r - 8'd1 : 8'd0;

  always_comb begin
    wr_slot_nxt  = wr_slot_r;
    rd_slot_nxt  = rd_slot_r;
    cur_nxt      = cur_r;
    beeps_nxt    = beeps_r;
    deadline_nxt = deadline_r;
    running_nxt  = running_r;
    on_phase_nxt = on_phase_r;
    gap_nxt      = gap_r;
    steady_nxt   = steady_r;
    drive_nxt    = drive_r;
    acc          = 1'b0;
    mem_we       = 1'b0;

    case (item_r.func)
      FN_TICK: begin
        if (!steady_r) begin
          if (!running_r) begin
            if (!q_empty && (!gap_r || reached)) begin
              gap_nxt      = 1'b0;
              cur_nxt      = head_r;
              rd_slot_nxt  = next_slot(rd_slot_r);
              beeps_nxt    = head_r.reps;
              running_nxt  = 1'b1;
              on_phase_nxt = 1'b1;
              drive_nxt    = 1'b1;
              deadline_nxt = item_r.time_now + 32'(head_r.on_t);
            end
          end else if (reached) begin
            if (on_phase_r) begin
              drive_nxt    = 1'b0;
              beeps_nxt    = beeps_dec;
              on_phase_nxt = 1'b0;
              deadline_nxt = item_r.time_now + 32'(cur_r.off_t);
              if (beeps_dec == 8'd0) begin
                running_nxt = 1'b0;
                gap_nxt     = !q_empty && (cur_r.off_t != 16'd0);
              end
            end else begin
              on_phase_nxt = 1'b1;
              drive_nxt    = 1'b1;
              deadline_nxt = item_r.time_now + 32'(cur_r.on_t);
            end
          end
        end
      end
      FN_PLAY: begin
        if ((item_r.on_time != 16'd0) && (item_r.beep_count != 8'd0) && !steady_r &&
            (wr_next != rd_slot_r)) begin
          mem_we      = 1'b1;
          wr_slot_nxt = wr_next;
          acc         = 1'b1;
        end
      end
      FN_STOP: begin
        wr_slot_nxt  = '0;
        rd_slot_nxt  = '0;
        running_nxt  = 1'b0;
        on_phase_nxt = 1'b0;
        gap_nxt      = 1'b0;
        steady_nxt   = 1'b0;
        drive_nxt    = 1'b0;
      end
      FN_CONT: begin
        if (item_r.continuous_enable) begin
          wr_slot_nxt  = '0;
          rd_slot_nxt  = '0;
          running_nxt  = 1'b0;
          on_phase_nxt = 1'b0;
          gap_nxt      = 1'b0;
          steady_nxt   = 1'b1;
          drive_nxt    = 1'b1;
        end else if (steady_r) begin
          steady_nxt = 1'b0;
          drive_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // queue memory: write at tail on accepted play, registered read of head
  always_ff @(posedge clk) begin
    if (cmd.execute && mem_we) begin
      pat_mem[wr_slot_r] <= '{on_t: item_r.on_time, off_t: item_r.off_time,
                              reps: item_r.beep_count};
    end
    if (cmd.capture) begin
      head_r <= pat_mem[rd_slot_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.execute) begin
      res_r.pin_level <= drive_nxt ? act_lvl_r : ~act_lvl_r;
      res_r.accepted  <= acc;
      res_r.busy_res  <= steady_nxt || running_nxt || (wr_slot_nxt != rd_slot_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_lvl_r  <= BOARD_ACTIVE_LEVEL;
      wr_slot_r  <= '0;
      rd_slot_r  <= '0;
      cur_r      <= '0;
      beeps_r    <= '0;
      deadline_r <= '0;
      running_r  <= 1'b0;
      on_phase_r <= 1'b0;
      gap_r      <= 1'b0;
      steady_r   <= 1'b0;
      drive_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        act_lvl_r <= cfg_wdata;
      end
      if (cmd.execute) begin
        wr_slot_r  <= wr_slot_nxt;
        rd_slot_r  <= rd_slot_nxt;
        cur_r      <= cur_nxt;
        beeps_r    <= beeps_nxt;
        deadline_r <= deadline_nxt;
        running_r  <= running_nxt;
        on_phase_r <= on_phase_nxt;
        gap_r      <= gap_nxt;
        steady_r   <= steady_nxt;
        drive_r    <= drive_nxt;
      end
    end
  end

  assign out_result = res_r;

endmodule

// ===== hdl/buzzer_pattern_queue_player.sv =====
// Top level of the buzzer beep pattern player with a pattern queue.
// Depends on bpq_pkg, bpq_ctrl, bpq_dp and the assertion macro header.
`include "buzzer_pattern_queue_player_assert.svh"

// Buzzer pattern player. A transaction is taken at a rising edge with start
// high and busy low; busy is then high for one cycle while the item is
// applied, and the result shows on out_result for exactly one cycle with
// out_strobe high, once the execute state has loaded the result register.
// The receiver cannot stall. A new transaction may be started in the same
// cycle the previous result is shown, but not while busy; the queue head
// is read from pattern memory into a register as a transaction is taken.
// Functions: tick (time_now in ms, starts or advances a pattern, deadlines
// compared wrap-safe), play (queues on_time, off_time, beep_count; refused
// when on_time or beep_count is zero, continuous mode is on, or the queue
// is full; QUEUE_DEPTH-1 usable slots), stop all, and set or clear
// continuous mode. If a pattern is queued at the last beep, a gap of the
// ended pattern's off time is kept first. cfg_wdata sets the pin level
// that sounds the buzzer (reset 1); write it only while idle.
module buzzer_pattern_queue_player
  import bpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_result_t out_result,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  bpq_cmd_t cmd;

  // sequencing: idle -> execute -> idle, strobe in the cycle after execute
  bpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // queue memory, pattern timing state and result register
  bpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_result (out_result)
  );

  // an accepted transaction goes to work on the next cycle
  `BPQ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction not executed")
  // each executed transaction gives exactly one result, right after
  `BPQ_ASSERT(a_exec_strobe, busy |=> (out_strobe && !busy), "missing result after execute")
  // only a play transaction can report accepted
  `BPQ_ASSERT(a_acc_play, (out_strobe && out_result.accepted) |->
              ($past(in_item.func, 2) == FN_PLAY), "accepted set for non-play")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for buzzer_pattern_queue_player: a scoreboard class predicts
// every result, plain tasks drive the command port. Depends on bpq_pkg and the RTL.
module tb;
  import bpq_pkg::*;

  // Scoreboard: carries its own copy of the player state. Each accepted command
  // is run through the predictor and its result is queued; each strobed result
  // is checked against the oldest queued one.
  class beep_scoreboard;
    pat_t              slots[QUEUE_DEPTH];
    logic [SLOT_W-1:0] wr_ptr;
    logic [SLOT_W-1:0] rd_ptr;
    pat_t              playing;
    logic [7:0]        beeps_left;
    logic [31:0]       due_ms;
    bit                running;
    bit                on_phase;
    bit                gap_hold;
    bit                steady;
    bit                drive;
    bit                level;
    out_result_t       pending_results[$];
    int                mismatches;
    int                n_items;
    int                n_checked;
    int                n_queued;
    int                n_launches;

    function new();
      for (int i = 0; i < QUEUE_DEPTH; i++) slots[i] = '0;
      playing    = '0;
      beeps_left = '0;
      due_ms     = '0;
      level      = BOARD_ACTIVE_LEVEL;
      clear_all();
    endfunction

    task flag(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function logic [SLOT_W-1:0] bump(input logic [SLOT_W-1:0] s);
      return SLOT_W'((int'(s) + 1) % QUEUE_DEPTH);
    endfunction

    // wrap-safe: the deadline has passed when (now - due) is not negative
    function bit deadline_hit(input logic [31:0] now);
      logic [31:0] diff;
      diff = now - due_ms;
      return !diff[31];
    endfunction

    function void clear_all();
      wr_ptr   = '0;
      rd_ptr   = '0;
      running  = 0;
      on_phase = 0;
      gap_hold = 0;
      steady   = 0;
      drive    = 0;
    endfunction

    function void launch_next(input logic [31:0] now);
      if (wr_ptr == rd_ptr) return;
      if (gap_hold) begin
        if (!deadline_hit(now)) return;
        gap_hold = 0;
      end
      playing    = slots[rd_ptr];
      rd_ptr     = bump(rd_ptr);
      beeps_left = playing.reps;
      running    = 1;
      on_phase   = 1;
      drive      = 1;
      due_ms     = now + 32'(playing.on_t);
      n_launches++;
    endfunction

    function void on_tick(input logic [31:0] now);
      if (steady) return;
      if (!running) begin
        launch_next(now);
        return;
      end
      if (!deadline_hit(now)) return;
      if (on_phase) begin
        drive = 0;
        if (beeps_left != 0) beeps_left--;
        on_phase = 0;
        due_ms   = now + 32'(playing.off_t);
        if (beeps_left == 0) begin
          running = 0;
          // off gap only when something is waiting and there is a gap to keep
          gap_hold = (wr_ptr != rd_ptr) && (playing.off_t != 0);
        end
      end else begin
        on_phase = 1;
        drive    = 1;
        due_ms   = now + 32'(playing.on_t);
      end
    endfunction

    function void note_input(input in_item_t it);
      out_result_t want;
      bit          took;
      took = 0;
      case (it.func)
        FN_TICK: on_tick(it.time_now);
        FN_PLAY: begin
          if (it.on_time != 0 && it.beep_count != 0 && !steady
              && bump(wr_ptr) != rd_ptr) begin
            slots[wr_ptr] = '{on_t: it.on_time, off_t: it.off_time, reps: it.beep_count};
            wr_ptr = bump(wr_ptr);
            took   = 1;
            n_queued++;
          end
        end
        FN_STOP: clear_all();
        FN_CONT: begin
          if (it.continuous_enable) begin
            clear_all();
            steady = 1;
            drive  = 1;
          end else if (steady) begin
            steady = 0;
            drive  = 0;
          end
        end
        default: ;
      endcase
      want.pin_level = drive ? level : !level;
      want.accepted  = took;
      want.busy_res  = steady || running || (wr_ptr != rd_ptr);
      pending_results.push_back(want);
      n_items++;
    endfunction

    task check_result(input out_result_t got);
      out_result_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result %b with nothing outstanding", got));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.pin_level !== want.pin_level)
        flag($sformatf("pin_level got %b want %b", got.pin_level, want.pin_level));
      if (got.accepted !== want.accepted)
        flag($sformatf("accepted got %b want %b", got.accepted, want.accepted));
      if (got.busy_res !== want.busy_res)
        flag($sformatf("busy_res got %b want %b", got.busy_res, want.busy_res));
    endtask
  endclass

  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 4;
  localparam int PER_PHASE   = 460;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_result_t out_result;
  logic        cfg_we;
  logic        cfg_wdata;

  beep_scoreboard sb;
  logic [31:0]    now_ms;       // running millisecond clock fed to ticks
  int             stall_cycles;
  int             cfg_writes;

  buzzer_pattern_queue_player DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitor: values are sampled as they were just before the edge. The result
  // check comes first, since a result at this edge always belongs to an
  // earlier transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) sb.check_result(out_result);
      if (start && !busy) sb.note_input(in_item);
    end
  end

  // Watchdog: ends the run if neither a command nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Fully random fields; used for noise commands and for the bus while idle.
  function automatic in_item_t junk_item();
    in_item_t it;
    it.func              = func_t'($urandom_range(0, 3));
    it.time_now          = $urandom;
    it.on_time           = 16'($urandom);
    it.off_time          = 16'($urandom);
    it.beep_count        = 8'($urandom);
    it.continuous_enable = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_tick(input logic [31:0] t);
    in_item_t it;
    it          = junk_item();
    it.func     = FN_TICK;
    it.time_now = t;
    return it;
  endfunction

  function automatic in_item_t mk_play(input logic [15:0] on_t, input logic [15:0] off_t,
                                       input logic [7:0] reps);
    in_item_t it;
    it            = junk_item();
    it.func       = FN_PLAY;
    it.on_time    = on_t;
    it.off_time   = off_t;
    it.beep_count = reps;
    return it;
  endfunction

  function automatic in_item_t mk_ctrl(input func_t f, input bit en);
    in_item_t it;
    it                   = junk_item();
    it.func              = f;
    it.continuous_enable = en;
    return it;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random command mix. Ticks mostly move the clock a few ms so patterns play
  // out beep by beep; rare big jumps and resets of the clock cover wrap and
  // release patterns with huge times.
  function automatic in_item_t rand_item();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 52) begin
      s = $urandom_range(0, 99);
      if (s < 88)      now_ms = now_ms + $urandom_range(0, 9);
      else if (s < 95) now_ms = now_ms + $urandom_range(10, 200);
      else if (s < 98) now_ms = now_ms + $urandom;
      else             now_ms = $urandom;
      return mk_tick(now_ms);
    end
    if (r < 80) return mk_play(16'($urandom_range(1, 12)), 16'($urandom_range(0, 12)),
                               8'($urandom_range(1, 4)));
    if (r < 86) return mk_play(16'($urandom), 16'($urandom), 8'($urandom));
    if (r < 89) return mk_ctrl(FN_STOP, 1'b0);
    if (r < 91) return mk_ctrl(FN_CONT, 1'b1);
    if (r < 94) return mk_ctrl(FN_CONT, 1'b0);
    return junk_item();
  endfunction

  // Holds the command until the block takes it. start stays high on return so a
  // back-to-back command needs no second assignment in the same step.
  task automatic push_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start   <= 1'b0;
      in_item <= junk_item();
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result, plus a little slack.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_level(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.level   = v;
    cfg_writes++;
  endtask

  task automatic send(input in_item_t it);
    push_item(it);
    pause(pick_gap());
  endtask

  initial begin
    bit levels[PHASES];
    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b1;
    stall_cycles = 0;
    cfg_writes   = 0;
    levels       = '{1'b0, 1'b1, 1'b0, 1'b1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refusals, full queue, wrap, gaps, continuous mode, stop.
    send(mk_tick(32'h0));                          // empty queue, nothing happens
    send(mk_play(16'h0, 16'h5, 8'h2));             // zero on time refused
    send(mk_play(16'h4, 16'h5, 8'h0));             // zero repeat refused
    send(mk_play(16'h1, 16'h0, 8'h1));
    send(mk_play(16'hFFFF, 16'hFFFF, 8'hFF));
    send(mk_play(16'h2, 16'h3, 8'h2));
    send(mk_play(16'h2, 16'h3, 8'h2));             // queue full, refused
    send(mk_tick(32'hFFFF_FFFF));                  // start; deadline wraps to 0
    send(mk_tick(32'h0));                          // last beep, zero off time: no gap
    send(mk_tick(32'h1));                          // long pattern starts at once
    send(mk_tick(32'h8000_0000));
    send(mk_ctrl(FN_STOP, 1'b0));
    send(mk_ctrl(FN_CONT, 1'b0));                  // not in continuous: no effect
    send(mk_ctrl(FN_CONT, 1'b1));
    send(mk_play(16'h3, 16'h5, 8'h1));             // refused in continuous mode
    send(mk_tick(32'h10));                         // tick ignored in continuous mode
    send(mk_ctrl(FN_CONT, 1'b0));
    send(mk_play(16'h3, 16'h5, 8'h1));
    send(mk_play(16'h2, 16'h0, 8'h1));
    send(mk_tick(32'd100));
    send(mk_tick(32'd103));                        // last beep, queue waiting: gap to 108
    send(mk_tick(32'd105));                        // gap still running
    send(mk_tick(32'd108));                        // gap over, next pattern
    send(mk_tick(32'd110));                        // last beep, queue empty: no gap
    send(mk_ctrl(FN_STOP, 1'b0));

    // Random phases, active level changed between them while idle. The first
    // runs with the reset level; the last pair hits both extremes again.
    for (int p = 0; p < PHASES; p++) begin
      now_ms = (p == 1) ? 32'hFFFF_F000 : $urandom;
      for (int i = 0; i < PER_PHASE; i++) begin
        push_item(rand_item());
        if (i == PER_PHASE / 2) drain();               // hold off until all results are back
        else if (((i / 64) % 4) != 1) pause(pick_gap()); // every fourth block runs back to back
      end
      drain();
      write_level(levels[p]);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d transactions, %0d results checked, %0d patterns queued,",
             sb.n_items, sb.n_checked, sb.n_queued);
    $display("%0d pattern starts, %0d active level writes", sb.n_launches, cfg_writes);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
